>>> rtl/rcm_pkg.sv
// Package: shared constants, codes and types of the rendezvous channel matcher.
`timescale 1ns / 1ps
package rcm_pkg;
	localparam int NUM_CHANNELS = 16;
	localparam int QUEUE_DEPTH  = 16;
	localparam int CH_W         = 4;
	localparam int SLOT_W       = 4;
	localparam int CNT_W        = 5;
	localparam int ADDR_W       = CH_W + SLOT_W;
	localparam int STORE_SIZE   = NUM_CHANNELS * QUEUE_DEPTH;

	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_DESTROY = 2'd1;
	localparam logic [1:0] OP_SEND    = 2'd2;
	localparam logic [1:0] OP_RECV    = 2'd3;

	localparam logic [2:0] RK_WAKE    = 3'd0;
	localparam logic [2:0] RK_GRANT   = 3'd1;
	localparam logic [2:0] RK_DONE    = 3'd2;
	localparam logic [2:0] RK_BAD     = 3'd3;
	localparam logic [2:0] RK_NOFREE  = 3'd4;
	localparam logic [2:0] RK_FULL    = 3'd5;

	// Command word: front end to back end
	localparam logic [2:0] CMD_SIMPLE  = 3'd0; // one result, no store access
	localparam logic [2:0] CMD_PAIR    = 3'd1; // pop oldest waiter, two wakes
	localparam logic [2:0] CMD_DRAIN   = 3'd2; // wake all waiters then done
	localparam logic [2:0] CMD_PUSH    = 3'd3; // write waiter, no result

	typedef struct packed {
		logic [2:0]        cmd;
		logic [2:0]        kind;
		logic [CH_W-1:0]   channel;
		logic [7:0]        thread_id;
		logic [63:0]       data;
		logic              is_send;
		logic              dir_send;
		logic [SLOT_W-1:0] head;
		logic [CNT_W-1:0]  count;
	} cmd_t;

	typedef struct packed {
		logic [2:0]      result_kind;
		logic [7:0]      target_thread;
		logic [63:0]     wake_value;
		logic [CH_W-1:0] granted_channel;
		logic            last;
	} res_t;
endpackage

>>> rtl/rcm_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface rcm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  channel;
	logic [7:0]  thread_id;
	logic [63:0] send_value;
	modport source (output valid, opcode, channel, thread_id, send_value, input ready);
	modport sink (input valid, opcode, channel, thread_id, send_value, output ready);
endinterface

interface rcm_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [7:0]  target_thread;
	logic [63:0] wake_value;
	logic [3:0]  granted_channel;
	logic        last;
	modport source (output valid, result_kind, target_thread, wake_value, granted_channel, last,
		input ready);
	modport sink (input valid, result_kind, target_thread, wake_value, granted_channel, last,
		output ready);
endinterface

>>> rtl/rcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/rcm_front.sv
// Front end: accepts words, holds channel table, classifies into commands.
`timescale 1ns / 1ps
module rcm_front (
	input  logic         clk,
	input  logic         arst_n,
	rcm_req_if.sink      req,
	output rcm_pkg::cmd_t cmd,
	output logic         cmd_valid,
	input  logic         cmd_ready
);
	import rcm_pkg::*;

	logic [NUM_CHANNELS-1:0] in_use_q;
	logic [NUM_CHANNELS-1:0] senders_q;
	logic [SLOT_W-1:0]       head_q  [NUM_CHANNELS];
	logic [CNT_W-1:0]        count_q [NUM_CHANNELS];

	logic            free_found;
	logic [CH_W-1:0] free_ch;
	logic            is_send;
	logic            fire;
	cmd_t            c;

	assign req.ready = cmd_ready;
	assign cmd_valid = req.valid;
	assign fire      = req.valid && cmd_ready;
	assign is_send   = (req.opcode == OP_SEND);

	// Find lowest free channel
	always_comb begin
		free_found = 1'b0;
		free_ch    = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_ch    = CH_W'(i);
			end
		end
	end

	// Classify the request
	always_comb begin
		c           = '0;
		c.channel   = req.channel;
		c.thread_id = req.thread_id;
		c.data      = req.send_value;
		c.is_send   = is_send;
		c.dir_send  = senders_q[req.channel];
		c.head      = head_q[req.channel];
		c.count     = count_q[req.channel];
		c.cmd       = CMD_SIMPLE;
		if (req.opcode == OP_CREATE) begin
			c.kind    = free_found ? RK_GRANT : RK_NOFREE;
			c.channel = free_found ? free_ch : '0;
		end else if (!in_use_q[req.channel]) begin
			c.kind = RK_BAD;
		end else if (req.opcode == OP_DESTROY) begin
			c.cmd = CMD_DRAIN;
		end else if (count_q[req.channel] != '0 && senders_q[req.channel] != is_send) begin
			c.cmd = CMD_PAIR;
		end else if (count_q[req.channel] >= CNT_W'(QUEUE_DEPTH)) begin
			c.kind = RK_FULL;
		end else begin
			c.cmd = CMD_PUSH;
		end
	end
	assign cmd = c;

	// Update channel table on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			senders_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (fire) begin
			if (req.opcode == OP_CREATE && free_found) begin
				in_use_q[free_ch]  <= 1'b1;
				senders_q[free_ch] <= 1'b0;
				head_q[free_ch]    <= '0;
				count_q[free_ch]   <= '0;
			end else if (c.cmd == CMD_DRAIN) begin
				in_use_q[req.channel]  <= 1'b0;
				senders_q[req.channel] <= 1'b0;
				head_q[req.channel]    <= '0;
				count_q[req.channel]   <= '0;
			end else if (c.cmd == CMD_PAIR) begin
				head_q[req.channel]  <= SLOT_W'(head_q[req.channel] + 1'b1);
				count_q[req.channel] <= count_q[req.channel] - 1'b1;
			end else if (c.cmd == CMD_PUSH) begin
				senders_q[req.channel] <= is_send;
				count_q[req.channel]   <= count_q[req.channel] + 1'b1;
			end
		end
	end
endmodule

>>> rtl/rcm_back.sv
// Back end: takes commands, works the waiter store and emits result words.
`timescale 1ns / 1ps
module rcm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rcm_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	rcm_res_if.source     res
);
	import rcm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1; // read issued, data next cycle
	localparam logic [2:0] ST_EMIT  = 3'd2; // present waiter wake
	localparam logic [2:0] ST_EMIT2 = 3'd3; // second word of a pair
	localparam logic [2:0] ST_DONE  = 3'd4; // final word of a drain

	logic [2:0]       state_q;
	cmd_t             c_q;
	logic [CNT_W-1:0] idx_q;
	logic             ovalid_q;
	res_t             out_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rd_thr;
	logic [63:0]       rd_val;
	logic              out_free;
	logic              cmd_fire;
	logic [SLOT_W-1:0] rslot;

	assign out_free  = !ovalid_q || res.ready;
	assign cmd_ready = (state_q == ST_IDLE) && out_free;
	assign cmd_fire  = cmd_valid && cmd_ready;

	assign we    = cmd_fire && cmd.cmd == CMD_PUSH;
	assign waddr = {cmd.channel, SLOT_W'(cmd.head + cmd.count[SLOT_W-1:0])};
	assign rslot = (state_q == ST_IDLE) ? cmd.head : SLOT_W'(c_q.head + idx_q[SLOT_W-1:0]);
	assign raddr = (state_q == ST_IDLE) ? {cmd.channel, rslot} : {c_q.channel, rslot};

	rcm_ram #(.WIDTH(8), .DEPTH(STORE_SIZE)) u_thr (
		.clk(clk), .we(we), .waddr(waddr), .wdata(cmd.thread_id),
		.raddr(raddr), .rdata(rd_thr)
	);
	rcm_ram #(.WIDTH(64), .DEPTH(STORE_SIZE)) u_val (
		.clk(clk), .we(we), .waddr(waddr), .wdata(cmd.is_send ? cmd.data : 64'd0),
		.raddr(raddr), .rdata(rd_val)
	);

	assign res.valid           = ovalid_q;
	assign res.result_kind     = out_q.result_kind;
	assign res.target_thread   = out_q.target_thread;
	assign res.wake_value      = out_q.wake_value;
	assign res.granted_channel = out_q.granted_channel;
	assign res.last            = out_q.last;

	// Sequence commands and load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
			c_q      <= '0;
			out_q    <= '0;
		end else begin
			if (res.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						c_q   <= cmd;
						idx_q <= '0;
						case (cmd.cmd)
							CMD_SIMPLE: begin
								ovalid_q <= 1'b1;
								out_q    <= '{cmd.kind, cmd.thread_id, 64'd0, cmd.channel, 1'b1};
							end
							CMD_PAIR:  state_q <= ST_READ;
							CMD_DRAIN: state_q <= (cmd.count == '0) ? ST_DONE : ST_READ;
							default:   ;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						if (c_q.cmd == CMD_PAIR) begin
							if (c_q.is_send) begin
								out_q <= '{RK_WAKE, c_q.thread_id, 64'd0, c_q.channel, 1'b0};
							end else begin
								out_q <= '{RK_WAKE, rd_thr, 64'd0, c_q.channel, 1'b0};
							end
							state_q <= ST_EMIT2;
						end else begin
							out_q <= '{RK_WAKE, rd_thr, {63'd0, c_q.dir_send}, c_q.channel,
								1'b0};
							idx_q <= idx_q + 1'b1;
							if (idx_q + 1'b1 == c_q.count) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_READ;
							end
						end
					end
				end
				ST_EMIT2: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						if (c_q.is_send) begin
							out_q <= '{RK_WAKE, rd_thr, c_q.data, c_q.channel, 1'b1};
						end else begin
							out_q <= '{RK_WAKE, c_q.thread_id, rd_val, c_q.channel, 1'b1};
						end
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						out_q    <= '{RK_DONE, c_q.thread_id, 64'd0, c_q.channel, 1'b1};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/rendezvous_channel_matcher_top.sv
// Top level: rendezvous channel matcher, front end, command queue and back end.
`timescale 1ns / 1ps
// Unbuffered channel engine. Each request word is classified combinationally
// by the front end against the channel table and handed through a two-entry
// command queue to the back end, which owns the waiter store (two RAMs with
// registered read). Create and rejected requests give one result word, waits
// are stored with no result; a pairing send or receive is accepted, reads the
// store and gives two result words; a destroy reads and wakes each queued
// waiter, then gives the final done word. The result port is registered, so
// the front end keeps accepting while results wait, until the queue is full.
module rendezvous_channel_matcher_top (
	input  logic     clk,
	input  logic     arst_n,
	rcm_req_if.sink  req,
	rcm_res_if.source res
);
	import rcm_pkg::*;

	cmd_t fcmd;
	logic fvalid;
	logic fready;
	cmd_t bcmd;
	logic bvalid;
	logic bready;

	cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       wr_q;
	logic       push;
	logic       pop;

	rcm_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.cmd(fcmd), .cmd_valid(fvalid), .cmd_ready(fready)
	);

	// Two-entry command queue between front and back
	assign fready = (cnt_q != 2'd2);
	assign bvalid = (cnt_q != 2'd0);
	assign bcmd   = q_q[rd_q];
	assign push   = fvalid && fready;
	assign pop    = bvalid && bready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= fcmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	rcm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(bcmd), .cmd_valid(bvalid), .cmd_ready(bready), .res(res)
	);
endmodule
